### rtl/core/fpa_pkg.sv
// shared types and constants of the fixed-point alu
package fpa_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int DIV_BITS   = 32 + FRAC_BITS;
   localparam int NUM_STAGES = DIV_BITS + 1;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_LT     = 4'd4,
      OP_GT     = 4'd5,
      OP_LE     = 4'd6,
      OP_GE     = 4'd7,
      OP_EQ     = 4'd8,
      OP_NE     = 4'd9,
      OP_INC    = 4'd10,
      OP_DEC    = 4'd11,
      OP_MIN    = 4'd12,
      OP_MAX    = 4'd13,
      OP_TO_INT = 4'd14
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic [31:0]        a_mag;
      logic [31:0]        b_mag;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic                valid;
      op_type              op;
      logic [31:0]         val;
      logic                cmp;
      logic                neg;
      logic                dz;
      logic signed [63:0]  prod;
      logic [31:0]         rem;
      logic [DIV_BITS-1:0] nq;
      logic [31:0]         bmag;
   } stage_type;

endpackage

### rtl/core/fpa_front.sv
// front end: accepts transactions, decodes them and queues them for the back end
module fpa_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  logic [7:0]        req_tuser,   // opcode [3:0], zero [7:4]
   output fpa_pkg::queue_type q_out,
   input  logic              q_pop
);
   import fpa_pkg::*;

   item_type    q_mem_ff [QUEUE_DEPTH];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   item_type    dec_item;

   always_comb begin
      dec_item.op    = op_type'(req_tuser[3:0]);
      dec_item.a     = $signed(req_tdata[31:0]);
      dec_item.b     = $signed(req_tdata[63:32]);
      dec_item.a_mag = req_tdata[31] ? (32'd0 - req_tdata[31:0]) : req_tdata[31:0];
      dec_item.b_mag = req_tdata[63] ? (32'd0 - req_tdata[63:32]) : req_tdata[63:32];
   end

   assign req_tready = (count_ff != 2'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= dec_item;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = q_mem_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> count_ff != 2'd0) else $error("pop from empty queue");
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'(QUEUE_DEPTH)) && !q_pop |=> count_ff == 2'(QUEUE_DEPTH))
      else $error("full queue lost an entry");
`endif

endmodule

### rtl/core/fpa_back.sv
// back end: execution pipeline with multiplier and radix-2 divider stages
module fpa_back (
   input  logic               clock,
   input  logic               reset,
   input  fpa_pkg::queue_type q_in,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // value [31:0]
   output logic [7:0]         rsp_tuser    // compare_true [0], divide_by_zero [1], zero [7:2]
);
   import fpa_pkg::*;

   stage_type   stage_ff [NUM_STAGES];
   stage_type   stage_in [NUM_STAGES];
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_val_ff, out_val_in;
   logic        out_cmp_ff, out_cmp_in;
   logic        out_dz_ff, out_dz_in;
   logic        advance;

   function automatic stage_type setup(input item_type it, input logic vld);
      stage_type s;
      s       = '0;
      s.valid = vld;
      s.op    = it.op;
      s.prod  = it.a * it.b;
      s.nq    = {it.a_mag, FRAC_BITS'(0)};
      s.bmag  = it.b_mag;
      s.neg   = it.a[31] ^ it.b[31];
      s.dz    = (it.b == 32'sd0);
      case (it.op)
         OP_ADD:    s.val = it.a + it.b;
         OP_SUB:    s.val = it.a - it.b;
         OP_LT:     s.cmp = it.a < it.b;
         OP_GT:     s.cmp = it.a > it.b;
         OP_LE:     s.cmp = it.a <= it.b;
         OP_GE:     s.cmp = it.a >= it.b;
         OP_EQ:     s.cmp = it.a == it.b;
         OP_NE:     s.cmp = it.a != it.b;
         OP_INC:    s.val = it.a + 32'sd1;
         OP_DEC:    s.val = it.a - 32'sd1;
         OP_MIN:    s.val = (it.a < it.b) ? it.a : it.b;
         OP_MAX:    s.val = (it.a > it.b) ? it.a : it.b;
         OP_TO_INT: s.val = it.a >>> FRAC_BITS;
         default:   s.val = '0;
      endcase
      return s;
   endfunction

   function automatic stage_type step(input stage_type s, input int k);
      stage_type   r;
      logic [32:0] trial;
      logic        qbit;
      r     = s;
      trial = {s.rem, s.nq[DIV_BITS-1]};
      qbit  = (trial >= {1'b0, s.bmag});
      if (qbit) begin
         r.rem = 32'(trial - {1'b0, s.bmag});
      end else begin
         r.rem = trial[31:0];
      end
      r.nq = {s.nq[DIV_BITS-2:0], qbit};
      if ((k == 0) && (s.op == OP_MUL)) begin
         r.prod = s.prod[63] ? (64'sd0 - s.prod) : s.prod;
         r.neg  = s.prod[63];
      end
      if ((k == 1) && (s.op == OP_MUL)) begin
         r.val = s.neg ? (32'd0 - 32'(s.prod >> FRAC_BITS)) : 32'(s.prod >> FRAC_BITS);
      end
      return r;
   endfunction

   assign advance = !out_valid_ff || rsp_tready;
   assign q_pop   = advance && q_in.valid;

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         stage_in[k] = stage_ff[k];
      end
      if (advance) begin
         stage_in[0] = setup(q_in.item, q_in.valid);
         for (int k = 1; k < NUM_STAGES; k++) begin
            stage_in[k] = step(stage_ff[k-1], k - 1);
         end
      end
      // reset empties every stage
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            stage_in[k].valid = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_val_in   = out_val_ff;
      out_cmp_in   = out_cmp_ff;
      out_dz_in    = out_dz_ff;
      if (advance) begin
         out_valid_in = stage_ff[NUM_STAGES-1].valid;
         out_val_in   = stage_ff[NUM_STAGES-1].val;
         out_cmp_in   = stage_ff[NUM_STAGES-1].cmp;
         out_dz_in    = 1'b0;
         if (stage_ff[NUM_STAGES-1].op == OP_DIV) begin
            out_dz_in = stage_ff[NUM_STAGES-1].dz;
            if (stage_ff[NUM_STAGES-1].dz) begin
               out_val_in = '0;
            end else if (stage_ff[NUM_STAGES-1].neg) begin
               out_val_in = 32'd0 - stage_ff[NUM_STAGES-1].nq[31:0];
            end else begin
               out_val_in = stage_ff[NUM_STAGES-1].nq[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         stage_ff[k] <= stage_in[k];
      end
      out_val_ff <= out_val_in;
      out_cmp_ff <= out_cmp_in;
      out_dz_ff  <= out_dz_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = {6'd0, out_dz_ff, out_cmp_ff};

`ifndef SYNTHESIS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_in.valid) else $error("pop without queued item");
   a_flag_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1])) else $error("both flags set");
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 32'd0) else $error("dz with value");
`endif

endmodule

### rtl/core/fixed_point_alu.sv
// top level of the signed fixed-point alu
//
// usage:
//  - req channel carries one operation per transaction: opcode in req_tuser,
//    operand_a and operand_b packed in req_tdata, raw fixed-point bits
//  - rsp channel returns exactly one transaction per request, in order:
//    value in rsp_tdata, compare_true and divide_by_zero flags in rsp_tuser
//  - throughput is one transaction per cycle while the receiver keeps rsp_tready
//    high; the divider retires one quotient bit per pipeline stage
//  - all operations take the same path, so results never reorder
//  - a two-entry queue separates the decoding front end from the execution
//    pipeline; while a result waits with rsp_tready low, the pipeline and output
//    register hold, the queue fills and req_tready drops once both entries are taken
//  - synchronous active-high reset empties the queue and the pipeline;
//    no result is pending afterward
module fixed_point_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // operand_a [31:0], operand_b [63:32]
   input  logic [7:0]  req_tuser,   // opcode [3:0], zero [7:4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value [31:0]
   output logic [7:0]  rsp_tuser    // compare_true [0], divide_by_zero [1], zero [7:2]
);
   import fpa_pkg::*;

   // decoded operations waiting for the pipeline
   queue_type q_link;
   logic      q_pop;

   // front end: handshake, operand decode and magnitudes
   fpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_out      (q_link),
      .q_pop      (q_pop)
   );

   // back end: multiplier, divider stages and output register
   fpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_in       (q_link),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### dv/fixed_point_alu_checker.sv
// checker of the fixed-point alu: watches both channels, predicts results and compares
module fixed_point_alu_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [7:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [7:0]  rsp_tuser,
   output int          failures,
   output int          pending,
   output int          accepted_reqs,
   output int          accepted_rsps
);
   import fpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] value;
      logic        compare_true;
      logic        divide_by_zero;
   } alu_result_type;

   alu_result_type expected_results[$];

   function automatic alu_result_type compute_alu(logic [3:0] opcode, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      logic signed [63:0] prod;
      logic [63:0] mag, num, den;
      logic neg;
      r = '0;
      case (opcode)
         OP_ADD: r.value = a + b;
         OP_SUB: r.value = a - b;
         OP_MUL: begin
            prod = 64'(a) * 64'(b);
            neg = prod < 0;
            mag = neg ? -prod : prod;
            mag = mag >> FRAC_BITS;
            r.value = neg ? 32'(-mag) : 32'(mag);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
            end else begin
               num = (a < 0) ? -64'(a) : 64'(a);
               den = (b < 0) ? -64'(b) : 64'(b);
               mag = (num << FRAC_BITS) / den;
               neg = (a < 0) != (b < 0);
               r.value = neg ? 32'(-mag) : 32'(mag);
            end
         end
         OP_LT:     r.compare_true = a < b;
         OP_GT:     r.compare_true = a > b;
         OP_LE:     r.compare_true = a <= b;
         OP_GE:     r.compare_true = a >= b;
         OP_EQ:     r.compare_true = a == b;
         OP_NE:     r.compare_true = a != b;
         OP_INC:    r.value = a + 1;
         OP_DEC:    r.value = a - 1;
         OP_MIN:    r.value = (a < b) ? a : b;
         OP_MAX:    r.value = (a > b) ? a : b;
         OP_TO_INT: r.value = a >>> FRAC_BITS;
         default:   r = '0;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compute_alu(req_tuser[3:0], req_tdata[31:0],
                                                   req_tdata[63:32]));
            accepted_reqs++;
         end
         if (rsp_tvalid && rsp_tready) begin
            accepted_rsps++;
            if (expected_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result transaction: value %h user %h",
                           rsp_tdata, rsp_tuser);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.value || rsp_tuser[0] !== want.compare_true ||
                   rsp_tuser[1] !== want.divide_by_zero || rsp_tuser[7:2] !== 6'd0) begin
                  failures++;
                  if (failures <= 10)
                     $display({"mismatch at result %0d: expected value %h cmp %b dz %b,",
                               " got value %h user %h"},
                              accepted_rsps, want.value, want.compare_true,
                              want.divide_by_zero, rsp_tdata, rsp_tuser);
               end
            end
         end
      end
      pending = expected_results.size();
   end
endmodule

### dv/fixed_point_alu_test.sv
// testbench top of the fixed-point alu: stimulus, idling and verdict
module fixed_point_alu_test;
   import fpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 60;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // operand_a [31:0], operand_b [63:32]
   logic [7:0]  req_tuser = '0;   // opcode [3:0], zero [7:4]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // value [31:0]
   logic [7:0]  rsp_tuser;        // compare_true [0], divide_by_zero [1], zero [7:2]

   int failures, pending, accepted_reqs, accepted_rsps;
   int send_idle_pct, recv_idle_pct;
   int idle_cycles;
   bit timed_out = 0;

   fixed_point_alu dut (.*);

   fixed_point_alu_checker result_checker (.*);

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random, drawn anew on every falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (!reset)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("watchdog expired with %0d results outstanding", pending);
         $display("fixed_point_alu_test: FAIL");
         $finish;
      end
   end

   // random operand with bias toward the edges of the range
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(int'($urandom_range(8)) - 4);
         3: return 32'(int'($urandom_range(4096)) - 2048);
         4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   // one request transaction: present at falling edge, hold until accepted
   task automatic send_op(logic [3:0] opcode, logic [31:0] a, logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {4'd0, opcode};
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_phase(int count);
      logic [3:0] opcode;
      logic [31:0] a, b;
      repeat (count) begin
         opcode = 4'($urandom_range(15));
         a = pick_operand();
         // equal operands now and then for the compare and min/max ties
         b = ($urandom_range(7) == 0) ? a : pick_operand();
         if (opcode == OP_DIV && $urandom_range(9) == 0) b = '0;
         send_op(opcode, a, b);
      end
   endtask

   initial begin
      logic [31:0] edge_vals[5];
      edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0000_0100};
      send_idle_pct = 7;
      recv_idle_pct = 62;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every opcode incl. the unused one, then the extremes
      for (int op = 0; op < 16; op++)
         send_op(4'(op), 32'h0000_0380, 32'hffff_fe80);
      send_op(OP_DIV, 32'h0000_0500, 32'h0);          // zero divisor
      send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);  // quotient wraps
      send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);  // product wraps
      send_op(OP_MUL, 32'hffff_ffff, 32'h0000_0001);  // truncate toward zero
      send_op(OP_TO_INT, 32'hffff_ffff, 32'h0);       // rounds toward minus infinity
      send_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
      send_op(OP_DEC, 32'h8000_0000, 32'hffff_ffff);
      send_op(OP_MIN, edge_vals[0], edge_vals[1]);
      send_op(OP_MAX, edge_vals[3], edge_vals[3]);

      random_phase(480);
      send_idle_pct = 62;
      recv_idle_pct = 7;
      random_phase(480);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(480);
      req_tvalid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d requests and %0d results over all opcodes and edge operands,",
               accepted_reqs, accepted_rsps);
      $display("with sender and receiver stalls in turn and a stall-free stretch");
      if (failures == 0 && pending == 0)
         $display("fixed_point_alu_test: PASS");
      else
         $display("fixed_point_alu_test: FAIL");
      $finish;
   end
endmodule
